### hdl/lspc_pkg.sv
// Package for the least-served picker: shared types, field widths and codes.
// Used by lspc_ctrl, lspc_dp and least_served_picker_with_countdown.
`timescale 1ns / 1ps

package lspc_pkg;

  // Widths fixed by the input and result words
  localparam int unsigned MASK_W   = 5;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned SECS_W   = 4;
  localparam int unsigned UNITS_W  = 4;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // Event kinds carried in the input tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_TPS    = 1'b0;
  localparam logic REG_CSTART = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] tps;
    logic [SECS_W-1:0] cstart;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the input word
    logic step;       // apply the event, load the first result
    logic scan_step;  // compare one participant
    logic commit;     // bump winner count, load the pick result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic no_result;  // event causes nothing
    logic pick;       // countdown hit zero: a pick follows
    logic scan_last;  // scan is at the last participant
  } sts_t;

  typedef struct packed {
    logic               tens;
    logic [UNITS_W-1:0] units;
  } digits_t;

  // Split a value of 0..15 into decimal digits
  function automatic digits_t to_digits(input logic [SECS_W-1:0] value);
    digits_t d;
    d.tens  = (value >= SECS_W'(10));
    d.units = d.tens ? UNITS_W'(value - SECS_W'(10)) : UNITS_W'(value);
    return d;
  endfunction

endpackage

### hdl/least_served_picker_with_countdown.sv
// Top level of the least-served picker with countdown: stream ports, APB
// registers, and the lspc_ctrl / lspc_dp pair. Uses lspc_pkg.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        tdata: present_mask; tuser: req_type
//  m_axis    out        m_axis_tvalid/tready        tdata: digits, running; tuser: is_selection
//  apb       in         psel & penable & pwrite     ticks_per_second @0, countdown_start @4
//
//  One word at a time. An event with no result passes from accept through the
//  evaluate state back to ready; a countdown word also waits out any output stall.
//  A pick then scans the win counts one per cycle and commits the winner.
//  After reset the countdown is idle, all win counts are zero, and the input
//  is ready; a stalled m_axis holds its word and keeps s_axis closed.

module least_served_picker_with_countdown #(
  parameter int unsigned PARTICIPANTS = 5,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input words
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [4:0] present_mask
  input  logic                         s_axis_tuser,  // [0] req_type
  // result words
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [0] tens_digit, [4:1] units_digit,
                                                      // [5] running
  output logic                         m_axis_tuser,  // [0] is_selection
  output logic                         m_axis_tlast,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lspc_pkg::APB_AW-1:0]  paddr,
  input  logic [lspc_pkg::APB_DW-1:0]  pwdata,
  output logic [lspc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import lspc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  logic                 tens;
  logic [UNITS_W-1:0]   units;
  logic                 run;
  logic                 wr_en;

  // Register writes
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tps    <= TICK_W'(125);
      cfg_q.cstart <= SECS_W'(3);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_TPS:    cfg_q.tps    <= pwdata[TICK_W-1:0];
        REG_CSTART: cfg_q.cstart <= pwdata[SECS_W-1:0];
        default:    ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      REG_TPS:    prdata = APB_DW'(cfg_q.tps);
      REG_CSTART: prdata = APB_DW'(cfg_q.cstart);
      default:    prdata = '0;
    endcase
  end

  lspc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lspc_dp #(
    .PARTICIPANTS (PARTICIPANTS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_i          (cfg_q),
    .req_type_i     (s_axis_tuser),
    .present_mask_i (s_axis_tdata[MASK_W-1:0]),
    .tens_digit_o   (tens),
    .units_digit_o  (units),
    .is_selection_o (m_axis_tuser),
    .running_o      (run),
    .last_o         (m_axis_tlast)
  );

  // Pack the result word
  assign m_axis_tdata = {2'b00, run, units, tens};

endmodule

### hdl/lspc_ctrl.sv
// Controller state machine of the least-served picker.
// Sequences capture, event step, participant scan and result handshakes; uses lspc_pkg.
`timescale 1ns / 1ps

module lspc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lspc_pkg::cmd_t cmd_o,
  input  lspc_pkg::sts_t sts_i
);
  import lspc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEND_CNT,
    ST_SCAN,
    ST_COMMIT,
    ST_SEND_PICK
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   pick_q;

  // Commands decoded from the state
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == ST_IDLE) && in_valid_i && in_ready_q;
    cmd_o.step      = (state_q == ST_EVAL);
    cmd_o.scan_step = (state_q == ST_SCAN);
    cmd_o.commit    = (state_q == ST_COMMIT);
  end

  // State and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
      pick_q      <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            in_ready_q <= 1'b0;
            state_q    <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (sts_i.no_result) begin
            in_ready_q <= 1'b1;
            state_q    <= ST_IDLE;
          end else begin
            out_valid_q <= 1'b1;
            pick_q      <= sts_i.pick;
            state_q     <= ST_SEND_CNT;
          end
        end
        ST_SEND_CNT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (pick_q) begin
              state_q <= ST_SCAN;
            end else begin
              in_ready_q <= 1'b1;
              state_q    <= ST_IDLE;
            end
          end
        end
        ST_SCAN: begin
          if (sts_i.scan_last) begin
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_SEND_PICK;
        end
        ST_SEND_PICK: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  // Never take a word while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_q && out_valid_q))
    else $error("input ready while a result is pending");

  // A pick is committed only after a full scan
  a_commit_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |-> ($past(state_q) == ST_SCAN))
    else $error("commit without scan");

  // An accepted word closes the input until it is done
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_q) |=> !in_ready_q)
    else $error("input stayed open after accept");

endmodule

### hdl/lspc_dp.sv
// Datapath of the least-served picker: countdown, tick counter, win counts,
// minimum scan and result register. Uses lspc_pkg.
`timescale 1ns / 1ps

module lspc_dp #(
  parameter int unsigned PARTICIPANTS = 5,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lspc_pkg::cmd_t                  cmd_i,
  output lspc_pkg::sts_t                  sts_o,
  input  lspc_pkg::cfg_t                  cfg_i,
  input  logic                            req_type_i,
  input  logic [lspc_pkg::MASK_W-1:0]     present_mask_i,
  output logic                            tens_digit_o,
  output logic [lspc_pkg::UNITS_W-1:0]    units_digit_o,
  output logic                            is_selection_o,
  output logic                            running_o,
  output logic                            last_o
);
  import lspc_pkg::*;

  localparam int unsigned IDX_W = (PARTICIPANTS > 1) ? $clog2(PARTICIPANTS) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PARTICIPANTS - 1);

  // Event state
  logic              kind_q;
  logic [MASK_W-1:0] mask_q;
  logic              active_q;
  logic [TICK_W-1:0] tick_q;
  logic [SECS_W-1:0] secs_q;

  // Win counts and scan state
  logic [COUNT_BITS-1:0] counts_q [PARTICIPANTS];
  logic [IDX_W-1:0]      idx_q;
  logic [IDX_W-1:0]      best_q;
  logic [COUNT_BITS-1:0] best_cnt_q;
  logic                  found_q;

  // Result register
  digits_t dig_q;
  logic    sel_q;
  logic    run_q;
  logic    last_q;

  logic [TICK_W-1:0]       tick_next;
  logic [SECS_W-1:0]       secs_next;
  logic                    hit;
  logic [SECS_W-1:0]       show_val;
  logic [PARTICIPANTS-1:0] present_vec;
  logic [COUNT_BITS-1:0]   cur_cnt;
  logic                    take;
  logic [SECS_W-1:0]       pick_val;

  // Next tick and countdown values
  assign tick_next = tick_q + TICK_W'(1);
  assign secs_next = secs_q - SECS_W'(1);
  assign hit       = (tick_next == cfg_i.tps);
  assign show_val  = (kind_q == REQ_START) ? cfg_i.cstart : secs_next;

  // Event outcome
  always_comb begin
    sts_o           = '0;
    sts_o.no_result = (kind_q == REQ_START) ? active_q : (!active_q || !hit);
    sts_o.pick      = (kind_q == REQ_TICK) && active_q && hit && (secs_next == '0);
    sts_o.scan_last = (idx_q == IDX_LAST);
  end

  // Only participants covered by the mask can be present
  genvar g;
  generate
    for (g = 0; g < PARTICIPANTS; g++) begin : g_present
      if (g < MASK_W) begin : g_in
        assign present_vec[g] = mask_q[g];
      end else begin : g_out
        assign present_vec[g] = 1'b0;
      end
    end
  endgenerate

  assign cur_cnt  = counts_q[idx_q];
  assign take     = present_vec[idx_q] && (!found_q || (cur_cnt < best_cnt_q));
  assign pick_val = found_q ? (SECS_W'(best_q) + SECS_W'(1)) : '0;

  // Input capture and countdown state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tick_q   <= '0;
      secs_q   <= '0;
    end else if (cmd_i.step) begin
      if (kind_q == REQ_START) begin
        if (!active_q) begin
          active_q <= 1'b1;
          tick_q   <= '0;
          secs_q   <= cfg_i.cstart;
        end
      end else if (active_q) begin
        if (hit) begin
          tick_q <= '0;
          secs_q <= secs_next;
          if (secs_next == '0) begin
            active_q <= 1'b0;
          end
        end else begin
          tick_q <= tick_next;
        end
      end
    end
  end

  // Latched input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= req_type_i;
      mask_q <= present_mask_i;
    end
  end

  // Win counts, saturating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PARTICIPANTS; i++) begin
        counts_q[i] <= '0;
      end
    end else if (cmd_i.commit && found_q && (best_cnt_q != COUNT_MAX)) begin
      counts_q[best_q] <= best_cnt_q + COUNT_BITS'(1);
    end
  end

  // Minimum scan, one participant per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + IDX_W'(1);
      if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && take) begin
      best_q     <= idx_q;
      best_cnt_q <= cur_cnt;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      dig_q  <= to_digits(show_val);
      sel_q  <= 1'b0;
      run_q  <= 1'b1;
      last_q <= !sts_o.pick;
    end else if (cmd_i.commit) begin
      dig_q  <= to_digits(pick_val);
      sel_q  <= 1'b1;
      run_q  <= 1'b0;
      last_q <= 1'b1;
    end
  end

  assign tens_digit_o   = dig_q.tens;
  assign units_digit_o  = dig_q.units;
  assign is_selection_o = sel_q;
  assign running_o      = run_q;
  assign last_o         = last_q;

  // A pick never happens while the countdown is still running
  a_idle_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !active_q)
    else $error("pick while countdown active");

endmodule

### tb/sv/lspc_tb_pkg.sv
// Scoreboard for the least-served picker testbench: predicts the display
// words from accepted events and checks the words seen on m_axis. Uses lspc_pkg.
`timescale 1ns / 1ps

package lspc_tb_pkg;

  import lspc_pkg::*;

  localparam int unsigned NUM_PARTS = 5;
  localparam int unsigned WIN_BITS  = 16;

  // One display word, field by field
  typedef struct packed {
    logic               tens;
    logic [UNITS_W-1:0] units;
    logic               is_sel;
    logic               running;
    logic               last;
  } show_t;

  class picker_scoreboard;
    logic [WIN_BITS-1:0] wins[NUM_PARTS];
    bit                  counting;
    logic [TICK_W-1:0]   ticks;
    logic [SECS_W-1:0]   secs;
    logic [TICK_W-1:0]   tps;
    logic [SECS_W-1:0]   cstart;
    show_t               shows_due[$];
    int unsigned         errors;

    function new();
      foreach (wins[i]) wins[i] = '0;
      counting = 1'b0;
      ticks    = '0;
      secs     = '0;
      tps      = TICK_W'(125);
      cstart   = SECS_W'(3);
      errors   = 0;
    endfunction

    function void write_reg(input logic idx, input logic [APB_DW-1:0] value);
      if (idx == REG_TPS) tps = value[TICK_W-1:0];
      else cstart = value[SECS_W-1:0];
    endfunction

    function void push_show(input int unsigned value, input bit is_sel,
                            input bit running, input bit last);
      show_t s;
      s.tens    = 1'((value / 10) & 1);
      s.units   = UNITS_W'(value % 10);
      s.is_sel  = is_sel;
      s.running = running;
      s.last    = last;
      shows_due.push_back(s);
    endfunction

    // Fewest wins among those present, lowest index on a tie; 0 when empty
    function int unsigned least_served(input logic [MASK_W-1:0] mask);
      int best;
      best = -1;
      for (int i = 0; i < NUM_PARTS; i++) begin
        if (mask[i] && (best < 0 || wins[i] < wins[best])) best = i;
      end
      if (best < 0) return 0;
      if (wins[best] != '1) wins[best] = wins[best] + 1'b1;
      return best + 1;
    endfunction

    // Apply one accepted event and queue the words it causes
    function void note_event(input logic kind, input logic [MASK_W-1:0] mask);
      if (kind == REQ_START) begin
        if (!counting) begin
          counting = 1'b1;
          ticks    = '0;
          secs     = cstart;
          push_show(secs, 1'b0, 1'b1, 1'b1);
        end
      end else if (counting) begin
        ticks = ticks + 1'b1;
        if (ticks == tps) begin
          ticks = '0;
          secs  = secs - 1'b1;
          if (secs != '0) begin
            push_show(secs, 1'b0, 1'b1, 1'b1);
          end else begin
            push_show(0, 1'b0, 1'b1, 1'b0);
            counting = 1'b0;
            push_show(least_served(mask), 1'b1, 1'b0, 1'b1);
          end
        end
      end
    endfunction

    function void cmp_field(input string name, input int unsigned want,
                            input int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_show(input show_t got);
      show_t want;
      if (shows_due.size() == 0) begin
        $error("result word with none expected: tens %0d units %0d sel %0d run %0d last %0d",
               got.tens, got.units, got.is_sel, got.running, got.last);
        errors++;
        return;
      end
      want = shows_due.pop_front();
      cmp_field("tens_digit", want.tens, got.tens);
      cmp_field("units_digit", want.units, got.units);
      cmp_field("is_selection", want.is_sel, got.is_sel);
      cmp_field("running", want.running, got.running);
      cmp_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

### tb/sv/tb_least_served_picker_with_countdown.sv
// Testbench top for least_served_picker_with_countdown: drives events and APB
// writes, checks every display word. Depends on lspc_pkg and lspc_tb_pkg.
`timescale 1ns / 1ps

module tb_least_served_picker_with_countdown;

  import lspc_pkg::*;
  import lspc_tb_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;  // cycles with no handshake at all
  localparam int unsigned HOLD_CYCLES = 400;  // long sink stall
  localparam int unsigned SETTLE = NUM_PARTS + 15;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;   // [4:0] present_mask
  logic              s_axis_tuser;   // [0] req_type
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;   // [0] tens, [4:1] units, [5] running
  logic              m_axis_tuser;   // [0] is_selection
  logic              m_axis_tlast;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  picker_scoreboard sb;
  bit               stim_gaps;
  bit               sink_stalls;
  int unsigned      hold_reqs;

  least_served_picker_with_countdown #(
    .PARTICIPANTS(NUM_PARTS),
    .COUNT_BITS  (WIN_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One APB transfer: setup phase, access phase until pready, then an idle phase
  task automatic apb_xfer(input bit wr, input logic idx, input logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic idx, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] got;
    apb_xfer(1'b0, idx, '0, got);
    if (got !== want) begin
      $error("prdata: expected %0d, got %0d", want, got);
      sb.errors++;
    end
  endtask

  task automatic set_reg(input logic idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] unused;
    apb_xfer(1'b1, idx, value, unused);
    sb.write_reg(idx, value);
    check_reg(idx, value);
  endtask

  // Offer one event word, with random gaps ahead of it
  task automatic send_event(input logic kind, input logic [MASK_W-1:0] mask);
    while (stim_gaps && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, mask};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(kind, mask);
  endtask

  // Mostly start-then-ticks sequences; stray starts and idle ticks as noise
  task automatic send_random(input int unsigned n);
    int unsigned      done;
    logic             kind;
    logic [MASK_W-1:0] mask;
    done = 0;
    while (done < n) begin
      if (sb.counting) kind = ($urandom_range(99) < 93) ? REQ_TICK : REQ_START;
      else kind = ($urandom_range(99) < 85) ? REQ_START : REQ_TICK;
      if ((kind == REQ_TICK) == sb.counting) done++;
      case ($urandom_range(9))
        0:       mask = '0;
        1:       mask = '1;
        2:       mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
        default: mask = MASK_W'($urandom);
      endcase
      send_event(kind, mask);
    end
  endtask

  // Close the input, wait out all words, then let a pending scan finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.shows_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Sink: check accepted words, stall at random or hold off on request
  initial begin : sink
    int unsigned hold_cnt;
    int unsigned holds_done;
    show_t       got;
    hold_cnt   = 0;
    holds_done = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.tens    = m_axis_tdata[0];
        got.units   = m_axis_tdata[4:1];
        got.running = m_axis_tdata[5];
        got.is_sel  = m_axis_tuser;
        got.last    = m_axis_tlast;
        sb.check_show(got);
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        hold_cnt   = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(sink_stalls && $urandom_range(99) < 19);
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [MASK_W-1:0] pick_masks[7] = '{5'h1F, 5'h1F, 5'h10, 5'h01, 5'h1F, 5'h1F, 5'h1F};
    sb            = new();
    stim_gaps     = 1'b1;
    sink_stalls   = 1'b1;
    hold_reqs     = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_START;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers come up at their reset values
    check_reg(REG_TPS, 32'd125);
    check_reg(REG_CSTART, 32'd3);

    // Directed: one tick per second, one-second countdown
    set_reg(REG_TPS, 32'd1);
    set_reg(REG_CSTART, 32'd1);
    send_event(REQ_TICK, 5'h1F);   // tick while idle: ignored
    send_event(REQ_START, 5'h00);
    send_event(REQ_START, 5'h1F);  // start while running: ignored
    send_event(REQ_TICK, 5'h00);   // nobody present: shows 0
    // picks 1, 2, 5, 1, 3, 4, 2 by win count and index
    foreach (pick_masks[i]) begin
      send_event(REQ_START, ~pick_masks[i]);
      send_event(REQ_TICK, pick_masks[i]);
    end
    drain();

    // Zero countdown start wraps to a 16-step run
    set_reg(REG_TPS, 32'd2);
    set_reg(REG_CSTART, 32'd0);
    send_random(150);
    drain();

    // Countdown from 15, no gaps or stalls on either side
    stim_gaps   = 1'b0;
    sink_stalls = 1'b0;
    set_reg(REG_TPS, 32'd1);
    set_reg(REG_CSTART, 32'd15);
    send_random(150);
    drain();
    stim_gaps   = 1'b1;
    sink_stalls = 1'b1;

    // Slowest tick rates: 255, and 0 which wraps to 256
    set_reg(REG_TPS, 32'd255);
    set_reg(REG_CSTART, 32'd1);
    send_random(260);
    drain();
    set_reg(REG_TPS, 32'd0);
    set_reg(REG_CSTART, 32'd1);
    send_random(260);
    drain();

    // Sink holds off for a long stretch while events keep coming
    set_reg(REG_TPS, 32'd4);
    set_reg(REG_CSTART, 32'd5);
    hold_reqs++;
    send_random(200);
    drain();

    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### least_served_picker_with_countdown.f
hdl/lspc_pkg.sv
hdl/lspc_ctrl.sv
hdl/lspc_dp.sv
hdl/least_served_picker_with_countdown.sv
tb/sv/lspc_tb_pkg.sv
tb/sv/tb_least_served_picker_with_countdown.sv
